>>> design/lcfr_pkg.sv
// Package for the length and checksum frame receiver.
// Holds the phase and result kind codes, the long-length command and the result struct.
// No dependencies.
package lcfr_pkg;

    localparam logic [7:0]  LONG_CMD          = 8'h09;
    localparam logic [15:0] TIMEOUT_RESET     = 16'd1000;
    localparam int unsigned TIMEOUT_W         = 16;
    localparam int unsigned LEN_W             = 16;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_LEN_A = 3'd1,
        PH_LEN_B = 3'd2,
        PH_DATA  = 3'd3,
        PH_SUM   = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        K_CMD     = 3'd0,
        K_DATA    = 3'd1,
        K_GOOD    = 3'd2,
        K_BADSUM  = 3'd3,
        K_TIMEOUT = 3'd4
    } kind_t;

    typedef enum logic {
        OP_BYTE = 1'b0,
        OP_TICK = 1'b1
    } op_t;

    typedef struct packed {
        logic       valid;
        kind_t      kind;
        logic [7:0] value;
        logic       last;
    } result_t;

endpackage

>>> design/lcfr_frame_fsm.sv
// Frame parser state machine of the length and checksum frame receiver.
// Updates phase, length, sum and tick count for one item and gives its result.
// Depends on lcfr_pkg.
module lcfr_frame_fsm
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             step,
    input  lcfr_pkg::op_t                    op,
    input  logic [7:0]                       rx_byte,
    input  logic [lcfr_pkg::TIMEOUT_W-1:0]   timeout_ticks,
    output lcfr_pkg::result_t                res
);

    lcfr_pkg::phase_t                   phase_reg, phase_next;
    logic                               long_reg, long_next;
    logic [lcfr_pkg::LEN_W-1:0]         left_reg, left_next;
    logic [7:0]                         sum_reg, sum_next;
    logic [lcfr_pkg::TIMEOUT_W-1:0]     tick_reg, tick_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= lcfr_pkg::PH_IDLE;
            long_reg  <= 1'b0;
            left_reg  <= '0;
            sum_reg   <= '0;
            tick_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            long_reg  <= long_next;
            left_reg  <= left_next;
            sum_reg   <= sum_next;
            tick_reg  <= tick_next;
        end
    end

    always_comb
    begin
        logic [7:0]                     sum_add;
        logic [lcfr_pkg::LEN_W-1:0]     left_dec;
        logic [lcfr_pkg::TIMEOUT_W-1:0] tick_inc;

        sum_add    = sum_reg + rx_byte;
        left_dec   = (left_reg != '0) ? left_reg - 1'b1 : left_reg;
        tick_inc   = tick_reg + 1'b1;

        phase_next = phase_reg;
        long_next  = long_reg;
        left_next  = left_reg;
        sum_next   = sum_reg;
        tick_next  = tick_reg;
        res        = '{valid: 1'b0, kind: lcfr_pkg::K_CMD, value: 8'd0, last: 1'b0};

        if (op == lcfr_pkg::OP_TICK)
        begin
            if (phase_reg != lcfr_pkg::PH_IDLE)
            begin
                tick_next = tick_inc;
                if (tick_inc >= timeout_ticks)
                begin
                    phase_next = lcfr_pkg::PH_IDLE;
                    long_next  = 1'b0;
                    left_next  = '0;
                    sum_next   = '0;
                    tick_next  = '0;
                    res        = '{valid: 1'b1, kind: lcfr_pkg::K_TIMEOUT,
                                   value: 8'd0, last: 1'b1};
                end
            end
        end
        else
        begin
            unique case (phase_reg)
                lcfr_pkg::PH_IDLE:
                begin
                    phase_next = lcfr_pkg::PH_LEN_A;
                    long_next  = (rx_byte == lcfr_pkg::LONG_CMD);
                    left_next  = '0;
                    sum_next   = rx_byte;
                    tick_next  = '0;
                    res        = '{valid: 1'b1, kind: lcfr_pkg::K_CMD,
                                   value: rx_byte, last: 1'b0};
                end
                lcfr_pkg::PH_LEN_A:
                begin
                    sum_next = sum_add;
                    if (long_reg)
                    begin
                        left_next  = {rx_byte, 8'd0};
                        phase_next = lcfr_pkg::PH_LEN_B;
                    end
                    else
                    begin
                        left_next  = {8'd0, rx_byte};
                        phase_next = (rx_byte == 8'd0) ? lcfr_pkg::PH_SUM
                                                       : lcfr_pkg::PH_DATA;
                    end
                end
                lcfr_pkg::PH_LEN_B:
                begin
                    sum_next   = sum_add;
                    left_next  = {left_reg[15:8], rx_byte};
                    phase_next = ({left_reg[15:8], rx_byte} == 16'd0) ? lcfr_pkg::PH_SUM
                                                                      : lcfr_pkg::PH_DATA;
                end
                lcfr_pkg::PH_DATA:
                begin
                    sum_next  = sum_add;
                    left_next = left_dec;
                    if (left_dec == '0)
                    begin
                        phase_next = lcfr_pkg::PH_SUM;
                    end
                    res = '{valid: 1'b1, kind: lcfr_pkg::K_DATA, value: rx_byte, last: 1'b0};
                end
                lcfr_pkg::PH_SUM:
                begin
                    phase_next = lcfr_pkg::PH_IDLE;
                    long_next  = 1'b0;
                    left_next  = '0;
                    sum_next   = '0;
                    tick_next  = '0;
                    res        = '{valid: 1'b1,
                                   kind: (rx_byte == ~sum_reg) ? lcfr_pkg::K_GOOD
                                                               : lcfr_pkg::K_BADSUM,
                                   value: 8'd0, last: 1'b1};
                end
                default:
                begin
                    phase_next = lcfr_pkg::PH_IDLE;
                    long_next  = 1'b0;
                    left_next  = '0;
                    sum_next   = '0;
                    tick_next  = '0;
                end
            endcase
        end
    end

endmodule

>>> design/length_checksum_frame_receiver.sv
// Top level of the length and checksum frame receiver.
// Input register, frame parser and result register; depends on lcfr_pkg and lcfr_frame_fsm.
//
//   Channel   Direction  Payload                                   Accepted when
//   s_axis    in         tuser: op, tdata[7:0]: rx_byte            tvalid && tready
//   m_axis    out        tuser: kind, tdata[7:0]: value, tlast     tvalid && tready
//   cfg       in         cfg_wr_data: timeout_ticks                cfg_wr_en
//
// An item passes the input register, then the parser into the result register. One
// item is accepted every cycle while the result side keeps up. A stalled result holds
// the parser and, once the input register is full, the input side. Reset clears all
// control state and sets the timeout to 1000 ticks.
module length_checksum_frame_receiver
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        s_axis_tuser,   // [0] op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] value
    output logic [2:0]  m_axis_tuser,   // [2:0] kind
    output logic        m_axis_tlast,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);

    logic [lcfr_pkg::TIMEOUT_W-1:0] timeout_reg;
    logic                           in_valid_reg, in_valid_next;
    lcfr_pkg::op_t                  in_op_reg;
    logic [7:0]                     in_byte_reg;
    logic                           out_valid_reg, out_valid_next;
    lcfr_pkg::kind_t                out_kind_reg;
    logic [7:0]                     out_value_reg;
    logic                           out_last_reg;
    logic                           advance;
    logic                           step;
    logic                           s_accept;
    lcfr_pkg::result_t              res;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign step          = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= lcfr_pkg::TIMEOUT_RESET;
        end
        else if (cfg_wr_en)
        begin
            timeout_reg <= cfg_wr_data;
        end
    end

    always_comb
    begin
        if (s_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end

        if (advance)
        begin
            out_valid_next = step && res.valid;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_op_reg   <= lcfr_pkg::op_t'(s_axis_tuser);
            in_byte_reg <= s_axis_tdata;
        end
        if (step && res.valid)
        begin
            out_kind_reg  <= res.kind;
            out_value_reg <= res.value;
            out_last_reg  <= res.last;
        end
    end

    lcfr_frame_fsm u_frame_fsm
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .op            (in_op_reg),
        .rx_byte       (in_byte_reg),
        .timeout_ticks (timeout_reg),
        .res           (res)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_value_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

>>> design/lcfr_checker.sv
// Port checker for the length and checksum frame receiver, bound to the top level.
// Depends on lcfr_pkg and length_checksum_frame_receiver.
module lcfr_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic [2:0] m_axis_tuser,
    input logic       m_axis_tlast
);

    logic is_status;

    assign is_status = (m_axis_tuser == lcfr_pkg::K_GOOD) ||
                       (m_axis_tuser == lcfr_pkg::K_BADSUM) ||
                       (m_axis_tuser == lcfr_pkg::K_TIMEOUT);

    a_last_on_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tlast == is_status))
    else $error("tlast does not match a closing status item");

    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && is_status) |-> (m_axis_tdata == 8'd0))
    else $error("status item carries nonzero data");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
             && $stable(m_axis_tlast)))
    else $error("stalled result item changed");

endmodule

bind length_checksum_frame_receiver lcfr_checker u_lcfr_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

>>> dv/tb_length_checksum_frame_receiver.sv
// Testbench for the length and checksum frame receiver.
// Drives byte and tick items, predicts every result and compares it in order.
// Depends on lcfr_pkg and the length_checksum_frame_receiver RTL.
`timescale 1ns / 100ps

module tb_length_checksum_frame_receiver;

    localparam int unsigned       WATCHDOG_LIMIT = 2000;
    localparam int unsigned       HOLD_CYCLES    = 250;
    localparam int unsigned       PHASE_ITEMS    = 265;
    localparam lcfr_pkg::result_t NO_RESULT      = '{1'b0, lcfr_pkg::K_CMD, 8'h00, 1'b0};

    typedef struct packed {
        lcfr_pkg::op_t     op;
        logic [7:0]        rx;
        logic              typed;
        lcfr_pkg::result_t want;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = 16'h0000;

    // Frame state of the predictor.
    lcfr_pkg::phase_t fr_phase;
    logic             fr_long;
    logic [16:0]      fr_left;
    logic [7:0]       fr_sum;
    logic [15:0]      fr_ticks;
    logic [15:0]      timeout_cfg;

    lcfr_pkg::result_t expected_q[$];
    int unsigned mismatches = 0;
    int unsigned stim_count = 0;
    int unsigned tick_pct = 5;
    int unsigned quiet_cycles = 0;
    int unsigned hold_requests = 0;
    int unsigned holds_started = 0;
    int unsigned hold_left = 0;
    bit          tx_gaps_on = 1'b1;
    bit          rx_gaps_on = 1'b1;

    stim_row_t directed_rows [21] = '{
        '{lcfr_pkg::OP_TICK, 8'h00, 1'b1, NO_RESULT},
        '{lcfr_pkg::OP_BYTE, 8'h00, 1'b1, '{1'b1, lcfr_pkg::K_CMD, 8'h00, 1'b0}},
        '{lcfr_pkg::OP_BYTE, 8'h00, 1'b1, NO_RESULT},
        '{lcfr_pkg::OP_BYTE, 8'hFF, 1'b1, '{1'b1, lcfr_pkg::K_GOOD, 8'h00, 1'b1}},
        '{lcfr_pkg::OP_BYTE, 8'hFF, 1'b1, '{1'b1, lcfr_pkg::K_CMD, 8'hFF, 1'b0}},
        '{lcfr_pkg::OP_BYTE, 8'h02, 1'b1, NO_RESULT},
        '{lcfr_pkg::OP_BYTE, 8'h00, 1'b0, NO_RESULT},
        '{lcfr_pkg::OP_BYTE, 8'hFF, 1'b0, NO_RESULT},
        '{lcfr_pkg::OP_TICK, 8'hA5, 1'b1, NO_RESULT},
        '{lcfr_pkg::OP_BYTE, 8'h00, 1'b1, '{1'b1, lcfr_pkg::K_BADSUM, 8'h00, 1'b1}},
        '{lcfr_pkg::OP_BYTE, lcfr_pkg::LONG_CMD, 1'b1,
          '{1'b1, lcfr_pkg::K_CMD, lcfr_pkg::LONG_CMD, 1'b0}},
        '{lcfr_pkg::OP_BYTE, 8'h00, 1'b1, NO_RESULT},
        '{lcfr_pkg::OP_BYTE, 8'h03, 1'b1, NO_RESULT},
        '{lcfr_pkg::OP_BYTE, 8'h5A, 1'b0, NO_RESULT},
        '{lcfr_pkg::OP_BYTE, 8'hA5, 1'b0, NO_RESULT},
        '{lcfr_pkg::OP_BYTE, 8'h3C, 1'b0, NO_RESULT},
        '{lcfr_pkg::OP_BYTE, 8'hB8, 1'b1, '{1'b1, lcfr_pkg::K_GOOD, 8'h00, 1'b1}},
        '{lcfr_pkg::OP_BYTE, lcfr_pkg::LONG_CMD, 1'b1,
          '{1'b1, lcfr_pkg::K_CMD, lcfr_pkg::LONG_CMD, 1'b0}},
        '{lcfr_pkg::OP_BYTE, 8'h00, 1'b1, NO_RESULT},
        '{lcfr_pkg::OP_BYTE, 8'h00, 1'b1, NO_RESULT},
        '{lcfr_pkg::OP_BYTE, 8'hF6, 1'b1, '{1'b1, lcfr_pkg::K_GOOD, 8'h00, 1'b1}}
    };

    length_checksum_frame_receiver dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic void clear_frame();
        fr_phase = lcfr_pkg::PH_IDLE;
        fr_long  = 1'b0;
        fr_left  = '0;
        fr_sum   = '0;
        fr_ticks = '0;
    endfunction

    function automatic lcfr_pkg::result_t frame_step(lcfr_pkg::op_t op, logic [7:0] rx);
        lcfr_pkg::result_t r;
        r = NO_RESULT;
        if (op == lcfr_pkg::OP_TICK)
        begin
            if (fr_phase != lcfr_pkg::PH_IDLE)
            begin
                fr_ticks = fr_ticks + 16'd1;
                if (fr_ticks >= timeout_cfg)
                begin
                    clear_frame();
                    r = '{1'b1, lcfr_pkg::K_TIMEOUT, 8'h00, 1'b1};
                end
            end
        end
        else
        begin
            case (fr_phase)
                lcfr_pkg::PH_IDLE:
                begin
                    clear_frame();
                    fr_sum   = rx;
                    fr_long  = (rx == lcfr_pkg::LONG_CMD);
                    fr_phase = lcfr_pkg::PH_LEN_A;
                    r = '{1'b1, lcfr_pkg::K_CMD, rx, 1'b0};
                end
                lcfr_pkg::PH_LEN_A:
                begin
                    fr_sum = fr_sum + rx;
                    if (fr_long)
                    begin
                        fr_left  = {1'b0, rx, 8'h00};
                        fr_phase = lcfr_pkg::PH_LEN_B;
                    end
                    else
                    begin
                        fr_left  = {9'd0, rx};
                        fr_phase = (fr_left == 0) ? lcfr_pkg::PH_SUM : lcfr_pkg::PH_DATA;
                    end
                end
                lcfr_pkg::PH_LEN_B:
                begin
                    fr_sum   = fr_sum + rx;
                    fr_left  = {1'b0, fr_left[15:8], rx};
                    fr_phase = (fr_left == 0) ? lcfr_pkg::PH_SUM : lcfr_pkg::PH_DATA;
                end
                lcfr_pkg::PH_DATA:
                begin
                    fr_sum = fr_sum + rx;
                    if (fr_left != 0)
                        fr_left = fr_left - 17'd1;
                    if (fr_left == 0)
                        fr_phase = lcfr_pkg::PH_SUM;
                    r = '{1'b1, lcfr_pkg::K_DATA, rx, 1'b0};
                end
                lcfr_pkg::PH_SUM:
                begin
                    r = '{1'b1, (rx == ~fr_sum) ? lcfr_pkg::K_GOOD : lcfr_pkg::K_BADSUM,
                          8'h00, 1'b1};
                    clear_frame();
                end
                default:
                    clear_frame();
            endcase
        end
        return r;
    endfunction

    task automatic send_item(input lcfr_pkg::op_t op, input logic [7:0] rx,
                             input logic typed = 1'b0,
                             input lcfr_pkg::result_t want = NO_RESULT);
        lcfr_pkg::result_t r;
        while (tx_gaps_on && $urandom_range(99) < 32)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= rx;
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (!(op == lcfr_pkg::OP_TICK && fr_phase == lcfr_pkg::PH_IDLE))
            stim_count++;
        r = frame_step(op, rx);
        if (typed)
            r = want;
        if (r.valid)
            expected_q.push_back(r);
    endtask

    task automatic send_byte(input logic [7:0] rx);
        if ($urandom_range(99) < tick_pct)
            send_item(lcfr_pkg::OP_TICK, 8'($urandom_range(255)));
        send_item(lcfr_pkg::OP_BYTE, rx);
    endtask

    task automatic send_frame();
        logic [7:0]  cmd_byte;
        logic [15:0] frame_len;
        cmd_byte = ($urandom_range(3) == 0) ? lcfr_pkg::LONG_CMD : 8'($urandom_range(255));
        send_byte(cmd_byte);
        if (cmd_byte == lcfr_pkg::LONG_CMD)
        begin
            if ($urandom_range(39) == 0)
                frame_len = 16'($urandom_range(256, 300));
            else
                frame_len = 16'($urandom_range(12));
            send_byte(frame_len[15:8]);
            send_byte(frame_len[7:0]);
        end
        else
        begin
            if ($urandom_range(39) == 0)
                frame_len = 16'($urandom_range(255));
            else
                frame_len = 16'($urandom_range(12));
            send_byte(frame_len[7:0]);
        end
        repeat (frame_len)
            send_byte(8'($urandom_range(255)));
        if ($urandom_range(99) < 85)
            send_byte(~fr_sum);
        else
            send_byte(8'($urandom_range(255)));
    endtask

    // Broken traffic: a maximal long length cut short by timeout, or loose items.
    task automatic send_noise();
        if (timeout_cfg <= 16'd64 && $urandom_range(1) == 0)
        begin
            send_byte(lcfr_pkg::LONG_CMD);
            send_byte(8'hFF);
            send_byte(8'hFF);
            repeat ($urandom_range(4))
                send_byte(8'($urandom_range(255)));
            while (fr_phase != lcfr_pkg::PH_IDLE)
                send_item(lcfr_pkg::OP_TICK, 8'($urandom_range(255)));
        end
        else
        begin
            repeat ($urandom_range(1, 6))
                send_item(lcfr_pkg::op_t'($urandom_range(1)), 8'($urandom_range(255)));
        end
    endtask

    task automatic set_timeout(input logic [15:0] ticks);
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= ticks;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        timeout_cfg = ticks;
    endtask

    always @(posedge clk)
    begin
        lcfr_pkg::result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_q.size() == 0)
            begin
                $error("unexpected result: kind %0d value %0h last %0b",
                       m_axis_tuser, m_axis_tdata, m_axis_tlast);
                mismatches++;
            end
            else
            begin
                want = expected_q.pop_front();
                if (m_axis_tuser !== want.kind)
                begin
                    $error("kind: expected %0d, got %0d", want.kind, m_axis_tuser);
                    mismatches++;
                end
                if (m_axis_tdata !== want.value)
                begin
                    $error("value: expected %0h, got %0h", want.value, m_axis_tdata);
                    mismatches++;
                end
                if (m_axis_tlast !== want.last)
                begin
                    $error("last: expected %0b, got %0b", want.last, m_axis_tlast);
                    mismatches++;
                end
            end
        end
        if (hold_left != 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else if (holds_started != hold_requests)
        begin
            holds_started++;
            hold_left = HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= !(rx_gaps_on && $urandom_range(99) < 32);
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        logic [15:0] new_timeout;
        int unsigned phase_end;
        timeout_cfg = lcfr_pkg::TIMEOUT_RESET;
        clear_frame();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_item(directed_rows[i].op, directed_rows[i].rx,
                      directed_rows[i].typed, directed_rows[i].want);

        for (int p = 0; p < 7; p++)
        begin
            case (p)
                1: new_timeout = 16'd0;
                2: new_timeout = 16'd1;
                3: new_timeout = 16'd3;
                4: new_timeout = 16'hFFFF;
                5: new_timeout = 16'($urandom_range(2, 40));
                default: new_timeout = 16'($urandom_range(41, 2000));
            endcase
            if (p != 0)
                set_timeout(new_timeout);
            // One phase runs back to back on both sides; another holds the output off.
            tx_gaps_on = (p != 3);
            rx_gaps_on = (p != 3);
            tick_pct   = $urandom_range(3, 12);
            phase_end  = stim_count + PHASE_ITEMS;
            while (stim_count < phase_end)
            begin
                if (p == 5 && hold_requests == 0 && stim_count + 200 > phase_end)
                    hold_requests++;
                if ($urandom_range(99) < 88)
                    send_frame();
                else
                    send_noise();
            end
        end

        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
